FILE: hdl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared widths and item types for the circle coverage lattice counter.
// ----------------------------------------------------------------------------
package ccl_pkg;

	localparam int COORD_W = 10;
	localparam int RAD_W   = 8;
	localparam int CNT_W   = 20;

	localparam int OFS_W = RAD_W + 1;      // signed offset inside a bounding square
	localparam int PT_W  = COORD_W + 1;    // lattice point coordinate
	localparam int D_W   = COORD_W + 2;    // point minus center
	localparam int SQ_W  = 2 * D_W;        // squared distance along one axis
	localparam int SUM_W = SQ_W + 1;       // dx^2 + dy^2
	localparam int RR_W  = 2 * RAD_W;      // squared radius

	localparam int NCIRC = 3;

	localparam logic [1:0] CIRC_A = 2'd0;
	localparam logic [1:0] CIRC_B = 2'd1;
	localparam logic [1:0] CIRC_C = 2'd2;

	localparam logic [CNT_W-1:0] COUNT_LIMIT = {CNT_W{1'b1}};

	typedef struct packed {
		logic [COORD_W-1:0] center_a_x;
		logic [COORD_W-1:0] center_a_y;
		logic [RAD_W-1:0]   radius_a;
		logic [COORD_W-1:0] center_b_x;
		logic [COORD_W-1:0] center_b_y;
		logic [RAD_W-1:0]   radius_b;
		logic [COORD_W-1:0] center_c_x;
		logic [COORD_W-1:0] center_c_y;
		logic [RAD_W-1:0]   radius_c;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] covered_once;
		logic [CNT_W-1:0] covered_twice;
		logic [CNT_W-1:0] covered_thrice;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [RAD_W-1:0]   r;
	} circle_t;

	typedef circle_t [NCIRC-1:0] circle_set_t;

	typedef struct packed {
		logic            valid;
		logic            last;
		logic [1:0]      circ;
		logic [PT_W-1:0] px;
		logic [PT_W-1:0] py;
	} point_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [1:0]       circ;
		logic [NCIRC-1:0] covered;
	} hit_t;

endpackage

FILE: hdl/circle_coverage_lattice_count.sv
// ----------------------------------------------------------------------------
// circle_coverage_lattice_count
// Counts lattice points covered by exactly one, two and three circles.
// ----------------------------------------------------------------------------
// Input channel circles (valid/stall): three circles per item, each a signed
// center and an unsigned radius. Output channel counts (valid/stall): one
// result item per input item with the three coverage counts, saturating.
// Each circle's bounding square is scanned one lattice point per cycle; a
// point is counted only in the lowest-numbered circle that contains it.
// Each item's points pass through the single point test unit, circle by
// circle; the next item can be accepted once the counts move into the
// output register. Items are worked one at a time:
// circles_stall is high from acceptance until the counts move into the
// output register, so a new item may be accepted while a result waits.
// A stalled result holds in the output register; a further finished item
// waits in the counters until the register frees. Reset clears all control
// state and drops both valids.
// ----------------------------------------------------------------------------
module circle_coverage_lattice_count (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               circles_valid,
	output logic               circles_stall,
	input  ccl_pkg::in_item_t  circles,
	output logic               counts_valid,
	input  logic               counts_stall,
	output ccl_pkg::out_item_t counts
);

	logic                 pend_q;
	logic                 start;
	logic                 release_item;
	ccl_pkg::circle_set_t circ_set;
	ccl_pkg::point_t      pt_s1;
	ccl_pkg::hit_t        hit_s4;

	assign circles_stall = pend_q;
	assign start         = circles_valid && !pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (start) begin
			pend_q <= 1'b1;
		end else if (release_item) begin
			pend_q <= 1'b0;
		end
	end

	ccl_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (circles),
		.circles (circ_set),
		.pt_s1   (pt_s1)
	);

	ccl_test u_test (
		.clk     (clk),
		.arst_n  (arst_n),
		.circles (circ_set),
		.pt_s1   (pt_s1),
		.hit_s4  (hit_s4)
	);

	ccl_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.hit_s4       (hit_s4),
		.counts_stall (counts_stall),
		.counts_valid (counts_valid),
		.counts       (counts),
		.release_item (release_item)
	);

endmodule

FILE: hdl/ccl_scan.sv
// ----------------------------------------------------------------------------
// ccl_scan
// Holds the circles of one item and walks each circle's bounding square,
// one lattice point per cycle.
// ----------------------------------------------------------------------------
module ccl_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ccl_pkg::in_item_t   item,
	output ccl_pkg::circle_set_t circles,
	output ccl_pkg::point_t     pt_s1
);

	ccl_pkg::circle_set_t store_q;
	logic                 busy_q;
	logic [1:0]           circ_q;
	logic signed [ccl_pkg::OFS_W-1:0] ox_q, oy_q;

	logic signed [ccl_pkg::OFS_W-1:0] cur_r, nxt_r, start_r;
	logic [ccl_pkg::RAD_W-1:0]        nxt_rad;
	logic                             col_end, row_end, last_pt;
	logic signed [ccl_pkg::PT_W-1:0]  px, py;

	assign circles = store_q;
	assign cur_r   = $signed({1'b0, store_q[circ_q].r});
	assign nxt_rad = (circ_q == ccl_pkg::CIRC_A) ? store_q[ccl_pkg::CIRC_B].r
	                                             : store_q[ccl_pkg::CIRC_C].r;
	assign nxt_r   = $signed({1'b0, nxt_rad});
	assign start_r = $signed({1'b0, item.radius_a});
	assign col_end = (oy_q == cur_r);
	assign row_end = (ox_q == cur_r);
	assign last_pt = col_end && row_end && (circ_q == ccl_pkg::CIRC_C);

	assign px = ccl_pkg::PT_W'($signed(store_q[circ_q].cx)) + ccl_pkg::PT_W'(ox_q);
	assign py = ccl_pkg::PT_W'($signed(store_q[circ_q].cy)) + ccl_pkg::PT_W'(oy_q);

	always_ff @(posedge clk) begin
		if (start) begin
			store_q[ccl_pkg::CIRC_A] <= {item.center_a_x, item.center_a_y, item.radius_a};
			store_q[ccl_pkg::CIRC_B] <= {item.center_b_x, item.center_b_y, item.radius_b};
			store_q[ccl_pkg::CIRC_C] <= {item.center_c_x, item.center_c_y, item.radius_c};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			circ_q <= ccl_pkg::CIRC_A;
			ox_q   <= '0;
			oy_q   <= '0;
			pt_s1  <= '0;
		end else begin
			pt_s1.valid <= busy_q;
			pt_s1.last  <= last_pt;
			pt_s1.circ  <= circ_q;
			pt_s1.px    <= px;
			pt_s1.py    <= py;
			if (start) begin
				busy_q <= 1'b1;
				circ_q <= ccl_pkg::CIRC_A;
				ox_q   <= -start_r;
				oy_q   <= -start_r;
			end else if (busy_q) begin
				if (!col_end) begin
					oy_q <= oy_q + 1'b1;
				end else if (!row_end) begin
					ox_q <= ox_q + 1'b1;
					oy_q <= -cur_r;
				end else if (circ_q == ccl_pkg::CIRC_C) begin
					busy_q <= 1'b0;
				end else begin
					circ_q <= circ_q + 1'b1;
					ox_q   <= -nxt_r;
					oy_q   <= -nxt_r;
				end
			end
		end
	end

endmodule

FILE: hdl/ccl_test.sv
// ----------------------------------------------------------------------------
// ccl_test
// Three-stage point test: offsets, squares, sum and compare against r^2
// for all three circles.
// ----------------------------------------------------------------------------
module ccl_test (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ccl_pkg::circle_set_t circles,
	input  ccl_pkg::point_t      pt_s1,
	output ccl_pkg::hit_t        hit_s4
);

	logic       vld_s2, vld_s3;
	logic       last_s2, last_s3;
	logic [1:0] circ_s2, circ_s3;

	logic signed [ccl_pkg::D_W-1:0]  dx_s2 [ccl_pkg::NCIRC];
	logic signed [ccl_pkg::D_W-1:0]  dy_s2 [ccl_pkg::NCIRC];
	logic [ccl_pkg::RR_W-1:0]        rr_s2 [ccl_pkg::NCIRC];
	logic [ccl_pkg::SQ_W-1:0]        dx2_s3 [ccl_pkg::NCIRC];
	logic [ccl_pkg::SQ_W-1:0]        dy2_s3 [ccl_pkg::NCIRC];
	logic [ccl_pkg::RR_W-1:0]        rr_s3 [ccl_pkg::NCIRC];
	logic [ccl_pkg::NCIRC-1:0]       covered;

	always_comb begin
		for (int j = 0; j < ccl_pkg::NCIRC; j++) begin
			covered[j] = (ccl_pkg::SUM_W'(dx2_s3[j]) + ccl_pkg::SUM_W'(dy2_s3[j]))
			             <= ccl_pkg::SUM_W'(rr_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < ccl_pkg::NCIRC; j++) begin
			dx_s2[j]  <= ccl_pkg::D_W'($signed(pt_s1.px))
			             - ccl_pkg::D_W'($signed(circles[j].cx));
			dy_s2[j]  <= ccl_pkg::D_W'($signed(pt_s1.py))
			             - ccl_pkg::D_W'($signed(circles[j].cy));
			rr_s2[j]  <= ccl_pkg::RR_W'(circles[j].r) * ccl_pkg::RR_W'(circles[j].r);
			dx2_s3[j] <= ccl_pkg::SQ_W'(dx_s2[j]) * ccl_pkg::SQ_W'(dx_s2[j]);
			dy2_s3[j] <= ccl_pkg::SQ_W'(dy_s2[j]) * ccl_pkg::SQ_W'(dy_s2[j]);
			rr_s3[j]  <= rr_s2[j];
		end
		last_s2 <= pt_s1.last;
		circ_s2 <= pt_s1.circ;
		last_s3 <= last_s2;
		circ_s3 <= circ_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			hit_s4 <= '0;
		end else begin
			vld_s2         <= pt_s1.valid;
			vld_s3         <= vld_s2;
			hit_s4.valid   <= vld_s3;
			hit_s4.last    <= last_s3;
			hit_s4.circ    <= circ_s3;
			hit_s4.covered <= covered;
		end
	end

endmodule

FILE: hdl/ccl_accum.sv
// ----------------------------------------------------------------------------
// ccl_accum
// Counts each point once, in the lowest circle that holds it, and hands the
// finished counts to the output register.
// ----------------------------------------------------------------------------
module ccl_accum (
	input  logic               clk,
	input  logic               arst_n,
	input  ccl_pkg::hit_t      hit_s4,
	input  logic               counts_stall,
	output logic               counts_valid,
	output ccl_pkg::out_item_t counts,
	output logic               release_item
);

	logic [ccl_pkg::CNT_W-1:0] once_q, twice_q, thrice_q;
	logic                      done_q, out_vld_q;
	ccl_pkg::out_item_t        out_q;
	logic                      take;
	logic [1:0]                n_in;

	assign n_in = 2'($countones(hit_s4.covered));

	always_comb begin
		case (hit_s4.circ)
			ccl_pkg::CIRC_A: take = hit_s4.covered[0];
			ccl_pkg::CIRC_B: take = hit_s4.covered[1] && !hit_s4.covered[0];
			ccl_pkg::CIRC_C: take = hit_s4.covered[2] && !hit_s4.covered[0]
			                        && !hit_s4.covered[1];
			default:         take = 1'b0;
		endcase
	end

	assign release_item = done_q && (!out_vld_q || !counts_stall);
	assign counts_valid = out_vld_q;
	assign counts       = out_q;

	always_ff @(posedge clk) begin
		if (release_item) begin
			out_q <= '{covered_once: once_q, covered_twice: twice_q,
			           covered_thrice: thrice_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			once_q    <= '0;
			twice_q   <= '0;
			thrice_q  <= '0;
			done_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (hit_s4.valid) begin
				if (take) begin
					case (n_in)
						2'd1: if (once_q != ccl_pkg::COUNT_LIMIT) once_q <= once_q + 1'b1;
						2'd2: if (twice_q != ccl_pkg::COUNT_LIMIT) twice_q <= twice_q + 1'b1;
						2'd3: if (thrice_q != ccl_pkg::COUNT_LIMIT) thrice_q <= thrice_q + 1'b1;
						default: ;
					endcase
				end
				if (hit_s4.last) begin
					done_q <= 1'b1;
				end
			end
			if (release_item) begin
				out_vld_q <= 1'b1;
				once_q    <= '0;
				twice_q   <= '0;
				thrice_q  <= '0;
				done_q    <= 1'b0;
			end else if (out_vld_q && !counts_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the circle coverage lattice counter.
// ----------------------------------------------------------------------------
// Each circle triple handed to the block is scored column by column:
// every circle gives one vertical run of lattice points per x, and the
// lengths of the runs and their pairwise and triple overlaps yield the
// once, twice and thrice counts. Results are matched in order against
// those counts. A directed set covers zero radius, the largest radius,
// the coordinate extremes, nesting and disjoint circles. About a hundred
// random triples follow, most of them clustered so that they overlap.
// Both sides idle at random, and once the result side holds off long
// enough to back the block up to its input.
// ----------------------------------------------------------------------------
class coverage_scoreboard;
	ccl_pkg::out_item_t pending_counts[$];
	int unsigned n_errors;

	static function longint span(longint lo, longint hi);
		return (hi >= lo) ? hi - lo + 1 : 0;
	endfunction

	static function longint overlap_len(longint lo_a, longint hi_a, longint lo_b,
			longint hi_b);
		return span((lo_a > lo_b) ? lo_a : lo_b, (hi_a < hi_b) ? hi_a : hi_b);
	endfunction

	static function longint root_floor(longint n);
		longint lo, hi, mid;
		lo = 0;
		hi = longint'(1) << ccl_pkg::RAD_W;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	static function logic [ccl_pkg::CNT_W-1:0] sat_count(longint v);
		if (v < 0)
			return '0;
		if (v > longint'(ccl_pkg::COUNT_LIMIT))
			return ccl_pkg::COUNT_LIMIT;
		return v[ccl_pkg::CNT_W-1:0];
	endfunction

	static function ccl_pkg::out_item_t lattice_coverage(ccl_pkg::in_item_t it);
		longint cx[3], cy[3], rad[3], lo[3], hi[3];
		longint xmin, xmax, x, dx, h, s1, s2, s3, once, twice, thrice;
		int i;
		ccl_pkg::out_item_t res;
		cx[0] = longint'($signed(it.center_a_x));
		cy[0] = longint'($signed(it.center_a_y));
		rad[0] = longint'(it.radius_a);
		cx[1] = longint'($signed(it.center_b_x));
		cy[1] = longint'($signed(it.center_b_y));
		rad[1] = longint'(it.radius_b);
		cx[2] = longint'($signed(it.center_c_x));
		cy[2] = longint'($signed(it.center_c_y));
		rad[2] = longint'(it.radius_c);
		xmin = cx[0] - rad[0];
		xmax = cx[0] + rad[0];
		for (i = 1; i < 3; i++) begin
			if (cx[i] - rad[i] < xmin)
				xmin = cx[i] - rad[i];
			if (cx[i] + rad[i] > xmax)
				xmax = cx[i] + rad[i];
		end
		once = 0;
		twice = 0;
		thrice = 0;
		for (x = xmin; x <= xmax; x++) begin
			for (i = 0; i < 3; i++) begin
				dx = x - cx[i];
				if (dx * dx <= rad[i] * rad[i]) begin
					h = root_floor(rad[i] * rad[i] - dx * dx);
					lo[i] = cy[i] - h;
					hi[i] = cy[i] + h;
				end else begin
					lo[i] = 1;
					hi[i] = 0;
				end
			end
			s1 = span(lo[0], hi[0]) + span(lo[1], hi[1]) + span(lo[2], hi[2]);
			s2 = overlap_len(lo[0], hi[0], lo[1], hi[1])
			   + overlap_len(lo[0], hi[0], lo[2], hi[2])
			   + overlap_len(lo[1], hi[1], lo[2], hi[2]);
			s3 = overlap_len((lo[0] > lo[1]) ? lo[0] : lo[1],
				(hi[0] < hi[1]) ? hi[0] : hi[1], lo[2], hi[2]);
			thrice += s3;
			twice += s2 - 3 * s3;
			once += s1 - 2 * s2 + 3 * s3;
		end
		res.covered_once = sat_count(once);
		res.covered_twice = sat_count(twice);
		res.covered_thrice = sat_count(thrice);
		return res;
	endfunction

	task report_mismatch(string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		n_errors++;
	endtask

	function void note_circles(ccl_pkg::in_item_t it);
		pending_counts.push_back(lattice_coverage(it));
	endfunction

	task check_counts(ccl_pkg::out_item_t got);
		ccl_pkg::out_item_t want;
		if (pending_counts.size() == 0) begin
			report_mismatch($sformatf("unexpected item %0d/%0d/%0d", got.covered_once,
				got.covered_twice, got.covered_thrice));
			return;
		end
		want = pending_counts.pop_front();
		if (got.covered_once !== want.covered_once)
			report_mismatch($sformatf("covered_once %0d, want %0d",
				got.covered_once, want.covered_once));
		if (got.covered_twice !== want.covered_twice)
			report_mismatch($sformatf("covered_twice %0d, want %0d",
				got.covered_twice, want.covered_twice));
		if (got.covered_thrice !== want.covered_thrice)
			report_mismatch($sformatf("covered_thrice %0d, want %0d",
				got.covered_thrice, want.covered_thrice));
	endtask

	function int outstanding();
		return pending_counts.size();
	endfunction
endclass

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 100;
	localparam int TINY_FIRST = 20;
	localparam int TINY_LAST = 44;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int DRAIN_CYCLES = 50;
	localparam int unsigned WATCHDOG_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n;
	logic circles_valid;
	logic circles_stall;
	ccl_pkg::in_item_t circles;
	logic counts_valid;
	logic counts_stall;
	ccl_pkg::out_item_t counts;

	coverage_scoreboard sb = new();
	int results_seen = 0;
	int hold_off_at = 0;
	int unsigned idle_cycles = 0;

	wire took_circles = arst_n && circles_valid && !circles_stall;
	wire took_counts = arst_n && counts_valid && !counts_stall;

	circle_coverage_lattice_count u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.circles_valid (circles_valid),
		.circles_stall (circles_stall),
		.circles       (circles),
		.counts_valid  (counts_valid),
		.counts_stall  (counts_stall),
		.counts        (counts)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int idle_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 4);
		if (pick < 97)
			return $urandom_range(5, 30);
		return $urandom_range(50, 300);
	endfunction

	function automatic int jitter(int spread);
		return int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic ccl_pkg::in_item_t three_circles(int ax, int ay, int ar, int bx,
			int by, int br, int cx, int cy, int cr);
		ccl_pkg::in_item_t it;
		it.center_a_x = ccl_pkg::COORD_W'(ax);
		it.center_a_y = ccl_pkg::COORD_W'(ay);
		it.radius_a = ccl_pkg::RAD_W'(ar);
		it.center_b_x = ccl_pkg::COORD_W'(bx);
		it.center_b_y = ccl_pkg::COORD_W'(by);
		it.radius_b = ccl_pkg::RAD_W'(br);
		it.center_c_x = ccl_pkg::COORD_W'(cx);
		it.center_c_y = ccl_pkg::COORD_W'(cy);
		it.radius_c = ccl_pkg::RAD_W'(cr);
		return it;
	endfunction

	function automatic ccl_pkg::in_item_t random_circles(bit tiny);
		int rmax, spread, bx, by;
		rmax = tiny ? 3 : (($urandom_range(0, 9) == 0) ? 40 : 12);
		spread = ($urandom_range(0, 4) == 0) ? 512 : rmax + 2;
		bx = $urandom_range(0, 1023);
		by = $urandom_range(0, 1023);
		return three_circles(bx + jitter(spread), by + jitter(spread), $urandom_range(0, rmax),
			bx + jitter(spread), by + jitter(spread), $urandom_range(0, rmax),
			bx + jitter(spread), by + jitter(spread), $urandom_range(0, rmax));
	endfunction

	task automatic send_circles(ccl_pkg::in_item_t it, int gap);
		@(negedge clk);
		circles_valid <= 1'b1;
		circles <= it;
		do
			@(posedge clk);
		while (circles_stall);
		if (gap > 0) begin
			@(negedge clk);
			circles_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (took_circles)
			sb.note_circles(circles);
		if (took_counts) begin
			sb.check_counts(counts);
			results_seen <= results_seen + 1;
		end
	end

	always @(posedge clk) begin
		if (took_circles || took_counts)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** circle_coverage_lattice_count: FAILED **");
			$finish;
		end
	end

	initial begin : result_sink
		int stall_left, mode_left;
		bit choppy, held_off;
		counts_stall = 1'b0;
		stall_left = 0;
		mode_left = 0;
		choppy = 1'b1;
		held_off = 1'b0;
		forever begin
			@(negedge clk);
			if (!held_off && hold_off_at > 0 && results_seen >= hold_off_at) begin
				held_off = 1'b1;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (mode_left == 0) begin
				choppy = $urandom_range(0, 2) != 0;
				mode_left = $urandom_range(200, 3000);
			end
			mode_left--;
			if (stall_left > 0) begin
				counts_stall <= 1'b1;
				stall_left--;
			end else begin
				counts_stall <= 1'b0;
				if (choppy && $urandom_range(0, 3) == 0)
					stall_left = idle_len();
			end
		end
	end

	initial begin : stimulus
		ccl_pkg::in_item_t directed[$];
		int k;
		bit tiny;
		arst_n = 1'b0;
		circles_valid = 1'b0;
		circles = '0;

		directed.push_back(three_circles(0, 0, 0, 0, 0, 0, 0, 0, 0));
		directed.push_back(three_circles(-512, -512, 255, 511, 511, 0, -512, 511, 0));
		directed.push_back(three_circles(3, -4, 5, 3, -4, 5, 3, -4, 5));
		directed.push_back(three_circles(-20, 0, 2, 0, 0, 2, 20, 0, 2));
		directed.push_back(three_circles(0, 0, 2, 0, 0, 6, 10, 10, 1));
		directed.push_back(three_circles(0, 0, 1, 0, 0, 3, 0, 0, 6));
		directed.push_back(three_circles(0, 0, 4, 5, 0, 4, 10, 0, 4));
		directed.push_back(three_circles(0, 0, 3, 3, 0, 0, 0, 3, 0));
		directed.push_back(three_circles(511, 511, 7, -512, -512, 7, 511, -512, 7));
		directed.push_back(three_circles(-300, 200, 9, 100, 100, 4, 102, 101, 5));
		directed.push_back(three_circles(100, -100, 40, 120, -90, 30, 90, -110, 35));
		directed.push_back(three_circles(-5, 5, 0, -5, 5, 0, 40, 40, 3));
		hold_off_at = directed.size() + TINY_FIRST + 2;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			send_circles(directed[i], idle_len());
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			tiny = (k >= TINY_FIRST) && (k <= TINY_LAST);
			send_circles(random_circles(tiny),
				(k == RANDOM_ITEMS - 1) ? 1 : (tiny ? 0 : idle_len()));
		end

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.n_errors == 0)
			$display("** circle_coverage_lattice_count: PASSED **");
		else
			$display("** circle_coverage_lattice_count: FAILED **");
		$finish;
	end
endmodule
